// ===== hw/rtl/hid_pkg.sv =====
// ----------------------------------------------------------------------------
// hid_pkg
// Shared types and constants of the histogram intersection distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package hid_pkg;

   // width of one histogram bin on the input stream
   localparam int BIN_BITS   = 16;
   // width of each running sum, sums saturate at the top
   localparam int TOTAL_BITS = 24;

   // running sums of one histogram pair
   typedef struct packed {
      logic [TOTAL_BITS-1:0] key_total;
      logic [TOTAL_BITS-1:0] found_total;
      logic [TOTAL_BITS-1:0] minimum_total;
   } totals_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
      logic empty;
   } div_status_type;

endpackage : hid_pkg

`default_nettype wire

// ===== hw/rtl/hid_accum.sv =====
// ----------------------------------------------------------------------------
// hid_accum
// Saturating running sums of key bins, candidate bins and pairwise minima.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_accum (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         add_en,
   input  wire logic                         clear,
   input  wire logic [hid_pkg::BIN_BITS-1:0] key_bin,
   input  wire logic [hid_pkg::BIN_BITS-1:0] found_bin,
   output hid_pkg::totals_type               totals
);
   import hid_pkg::*;

   localparam int PAD_BITS = TOTAL_BITS + 1 - BIN_BITS;

   totals_type            totals_ff;
   totals_type            totals_in;
   logic [BIN_BITS-1:0]   min_bin;
   logic [TOTAL_BITS:0]   key_sum;
   logic [TOTAL_BITS:0]   found_sum;
   logic [TOTAL_BITS:0]   min_sum;

   // smaller bin of the pair
   assign min_bin = (key_bin < found_bin) ? key_bin : found_bin;

   // widened sums, the carry bit flags saturation
   assign key_sum   = {1'b0, totals_ff.key_total}     + {{PAD_BITS{1'b0}}, key_bin};
   assign found_sum = {1'b0, totals_ff.found_total}   + {{PAD_BITS{1'b0}}, found_bin};
   assign min_sum   = {1'b0, totals_ff.minimum_total} + {{PAD_BITS{1'b0}}, min_bin};

   // next sums
   always_comb begin
      totals_in = totals_ff;
      if (clear) begin
         totals_in = '0;
      end else if (add_en) begin
         totals_in.key_total     = key_sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}}
                                                       : key_sum[TOTAL_BITS-1:0];
         totals_in.found_total   = found_sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}}
                                                         : found_sum[TOTAL_BITS-1:0];
         totals_in.minimum_total = min_sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}}
                                                       : min_sum[TOTAL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         totals_ff <= '0;
      end else begin
         totals_ff <= totals_in;
      end
   end

   assign totals = totals_ff;

endmodule : hid_accum

`default_nettype wire

// ===== hw/rtl/hid_divider.sv =====
// ----------------------------------------------------------------------------
// hid_divider
// Restoring divider, one compare and subtract per cycle, giving
// floor(minimum_total * 2^FRACTION_BITS / min(key_total, found_total)).
// ----------------------------------------------------------------------------
`default_nettype none

module hid_divider #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  hid_pkg::totals_type           totals,
   output hid_pkg::div_status_type       status,
   output logic [FRACTION_BITS:0]        quotient
);
   import hid_pkg::*;

   localparam int CNT_BITS = $clog2(FRACTION_BITS + 2);
   localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(FRACTION_BITS + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [TOTAL_BITS:0]     rem_ff, rem_in;
   logic [TOTAL_BITS-1:0]   div_ff, div_in;
   logic [FRACTION_BITS:0]  quot_ff, quot_in;
   logic [TOTAL_BITS:0]     diff;
   logic                    fits;

   // shared compare and subtract
   assign diff = rem_ff - {1'b0, div_ff};
   assign fits = (rem_ff >= {1'b0, div_ff});

   // sequencing of the steps
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = STEPS;
         rem_in   = {1'b0, totals.minimum_total};
         div_in   = (totals.key_total < totals.found_total) ? totals.key_total
                                                            : totals.found_total;
         quot_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the shift never overflows
         rem_in   = fits ? {diff[TOTAL_BITS-1:0], 1'b0} : {rem_ff[TOTAL_BITS-1:0], 1'b0};
         quot_in  = {quot_ff[FRACTION_BITS-1:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   assign status.busy  = busy_ff;
   assign status.done  = done_ff;
   assign status.empty = (div_ff == '0);
   assign quotient     = quot_ff;

endmodule : hid_divider

`default_nettype wire

// ===== hw/rtl/histogram_intersection_distance.sv =====
// Timing: a bin pair without tlast is added to the registered sums, pairs stream back to back.
// A pair with tlast passes the sequencer through load, divide and finish before its result
// is offered; req_tready stays low from acceptance until the result enters the result slot,
// which is held off while an earlier result waits on rsp_tready. The restoring divider retires one
// quotient bit per cycle.
// Reset: synchronous, active high; clears the sums, the sequencer and the result slot.
// ----------------------------------------------------------------------------
// histogram_intersection_distance
// Accumulates histogram bin pairs and on the last pair returns the
// intersection distance in unsigned fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_intersection_distance #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request stream: key_bin [15:0], found_bin [31:16]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [2*hid_pkg::BIN_BITS-1:0]      req_tdata,
   input  wire logic                                req_tlast,
   // response stream: distance [FRACTION_BITS:0], zero fill above
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [((FRACTION_BITS+8)/8)*8-1:0]       rsp_tdata,
   // response flag: empty_histogram [0]
   output logic                                     rsp_tuser
);
   import hid_pkg::*;

   localparam int DIST_BITS = FRACTION_BITS + 1;
   localparam int RSP_BITS  = ((FRACTION_BITS + 8) / 8) * 8;
   localparam logic [DIST_BITS-1:0] ONE_FIXED = {1'b1, {FRACTION_BITS{1'b0}}};

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_LOAD   = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIST_BITS-1:0]  rsp_dist_ff, rsp_dist_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  req_fire;
   logic                  slot_free;
   logic                  div_start;
   logic                  sums_clear;
   totals_type            totals;
   div_status_type        div_status;
   logic [DIST_BITS-1:0]  quotient;

   assign req_tready = (state_ff == ST_ACCEPT);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == ST_LOAD);
   assign sums_clear = (state_ff == ST_LOAD);

   // running sums
   hid_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .add_en    (req_fire),
      .clear     (sums_clear),
      .key_bin   (req_tdata[BIN_BITS-1:0]),
      .found_bin (req_tdata[2*BIN_BITS-1:BIN_BITS]),
      .totals    (totals)
   );

   // shared divider
   hid_divider #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .totals   (totals),
      .status   (div_status),
      .quotient (quotient)
   );

   // sequencer and result slot
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_empty_in = rsp_empty_ff;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (req_fire && req_tlast) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = div_status.empty;
               rsp_dist_in  = div_status.empty ? '0 : (ONE_FIXED - quotient);
               state_in     = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_dist_ff  <= rsp_dist_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BITS-DIST_BITS){1'b0}}, rsp_dist_ff};
   assign rsp_tuser  = rsp_empty_ff;

`ifndef NO_ASSERTIONS
   // no new pair is taken while the divider runs
   a_ready_idle : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_status.busy)
      else $error("request accepted while divider busy");

   // a start always puts the divider to work
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> div_status.busy)
      else $error("divider did not start");

   // completion only arrives while the sequencer waits for it
   a_done_state : assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

   // an empty histogram always reports zero distance
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("empty histogram with nonzero distance");
`endif

endmodule : histogram_intersection_distance

`default_nettype wire

// ===== bench/histogram_intersection_distance_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_intersection_distance_test
// Streams bin pairs into the intersection distance block and checks every
// distance against a table or a cycle-free model of the three saturating sums
// and the Q1.16 division. Directed pairs cover empty histograms and the
// distance extremes. Random vectors follow, among them one long enough to
// saturate a sum, with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module histogram_intersection_distance_test;

   import hid_pkg::*;

   localparam int FRACTION   = 16;
   localparam int RSP_BITS   = ((FRACTION + 8) / 8) * 8;
   localparam int IDLE_PCT   = 23;
   localparam int WATCHDOG   = 3000;
   localparam int SETTLE     = 40;
   localparam int HOLD_LEN   = 200;
   localparam int SAT_BINS   = 260;
   localparam int SHORT_BINS = 170;

   // one expected distance
   typedef struct packed {
      logic [FRACTION:0] distance;
      logic              empty;
   } distance_result_type;

   // one row of the directed table
   typedef struct packed {
      logic [BIN_BITS-1:0] key;
      logic [BIN_BITS-1:0] found;
      logic                last;
      logic                typed;
      logic [FRACTION:0]   distance;
      logic                empty;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 21;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{16'h0000, 16'h0000, 1'b1, 1'b1, 17'h00000, 1'b1},   // empty right after reset
      '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 17'h00000, 1'b0},   // identical full bins
      '{16'hFFFF, 16'h0000, 1'b1, 1'b1, 17'h00000, 1'b1},   // candidate empty
      '{16'h0000, 16'hFFFF, 1'b1, 1'b1, 17'h00000, 1'b1},   // key empty
      '{16'h0001, 16'h0002, 1'b1, 1'b1, 17'h00000, 1'b0},
      '{16'hAAAA, 16'h5555, 1'b1, 1'b1, 17'h00000, 1'b0},
      '{16'h8000, 16'h0001, 1'b0, 1'b0, 17'h00000, 1'b0},
      '{16'h0001, 16'h8000, 1'b1, 1'b0, 17'h00000, 1'b0},
      '{16'h5555, 16'hAAAA, 1'b0, 1'b0, 17'h00000, 1'b0},
      '{16'hAAAA, 16'h5555, 1'b1, 1'b0, 17'h00000, 1'b0},
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 17'h00000, 1'b0},
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 17'h00000, 1'b0},
      '{16'h0000, 16'h0000, 1'b1, 1'b1, 17'h00000, 1'b1},   // empty over several pairs
      '{16'h0001, 16'h0000, 1'b0, 1'b0, 17'h00000, 1'b0},
      '{16'h0000, 16'h0001, 1'b1, 1'b1, 17'h10000, 1'b0},   // disjoint, distance 1.0
      '{16'hFFFF, 16'h0001, 1'b0, 1'b0, 17'h00000, 1'b0},
      '{16'h1234, 16'hFFFF, 1'b0, 1'b0, 17'h00000, 1'b0},
      '{16'h0003, 16'h0007, 1'b1, 1'b0, 17'h00000, 1'b0},
      '{16'h0001, 16'hFFFF, 1'b1, 1'b1, 17'h00000, 1'b0},
      '{16'hFFFF, 16'hFFFE, 1'b0, 1'b0, 17'h00000, 1'b0},
      '{16'h0001, 16'h0000, 1'b1, 1'b0, 17'h00000, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [2*BIN_BITS-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]   rsp_tdata;
   logic                  rsp_tuser;

   // running sums of the model
   logic [TOTAL_BITS-1:0] key_sum = '0;
   logic [TOTAL_BITS-1:0] found_sum = '0;
   logic [TOTAL_BITS-1:0] min_sum = '0;

   distance_result_type expected_distances[$];
   int                  error_count = 0;
   int                  hold_request = 0;
   bit                  steady = 1'b0;

   histogram_intersection_distance #(.FRACTION_BITS(FRACTION)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // add with saturation at the top of a sum
   function automatic logic [TOTAL_BITS-1:0] saturating_add(input logic [TOTAL_BITS-1:0] acc,
                                                            input logic [BIN_BITS-1:0] bin);
      logic [TOTAL_BITS:0] sum;
      sum = acc + bin;
      return sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
   endfunction

   // fold one bin pair into the sums, give the distance on the last pair
   function automatic bit accumulate_bin_pair(input logic [BIN_BITS-1:0] key,
                                              input logic [BIN_BITS-1:0] found,
                                              input logic last,
                                              output distance_result_type res);
      logic [63:0] denom;
      logic [63:0] quot;
      key_sum   = saturating_add(key_sum, key);
      found_sum = saturating_add(found_sum, found);
      min_sum   = saturating_add(min_sum, (key < found) ? key : found);
      res = '0;
      if (!last)
         return 1'b0;
      denom = (key_sum < found_sum) ? key_sum : found_sum;
      if (denom == 0) begin
         res.empty = 1'b1;
      end else begin
         quot = (64'(min_sum) << FRACTION) / denom;
         if (quot > (64'd1 << FRACTION))
            quot = 64'd1 << FRACTION;
         res.distance = (FRACTION + 1)'((64'd1 << FRACTION) - quot);
      end
      key_sum   = '0;
      found_sum = '0;
      min_sum   = '0;
      return 1'b1;
   endfunction

   // offer one bin pair and wait for the transaction, random gap first
   task automatic send_bin_pair(input logic [BIN_BITS-1:0] key, input logic [BIN_BITS-1:0] found,
                                input logic last, input logic typed,
                                input distance_result_type typed_res);
      distance_result_type res;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {found, key};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (accumulate_bin_pair(key, found, last, res))
         expected_distances.push_back(typed ? typed_res : res);
   endtask

   // sender goes quiet until every distance has come back
   task automatic drain_distances;
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (expected_distances.size() == 0);
   endtask

   // bin value biased toward the extremes
   function automatic logic [BIN_BITS-1:0] pick_bin;
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return BIN_BITS'($urandom_range(15));
         default: return BIN_BITS'($urandom);
      endcase
   endfunction

   // response side: compare each transaction, then choose next ready
   initial begin
      distance_result_type want;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_distances.size() == 0) begin
               $display("%0t: unexpected distance %0d empty %0b", $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_distances.pop_front();
               if (rsp_tdata !== RSP_BITS'(want.distance)) begin
                  $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                           rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== want.empty) begin
                  $display("%0t: empty_histogram expected %0b actual %0b", $time, want.empty,
                           rsp_tuser);
                  error_count++;
               end
            end
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("histogram_intersection_distance regression: fail");
      $finish;
   end

   // stimulus
   initial begin
      int sent;
      int vec;
      int len;
      bit zero_key;
      logic [BIN_BITS-1:0] key;
      logic [BIN_BITS-1:0] found;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_bin_pair(DIRECTED[i].key, DIRECTED[i].found, DIRECTED[i].last, DIRECTED[i].typed,
                       distance_result_type'{DIRECTED[i].distance, DIRECTED[i].empty});
      drain_distances();

      // one long vector: key sum saturates, candidate sum stays below the top
      for (int i = 0; i < SAT_BINS; i++) begin
         key   = BIN_BITS'($urandom_range(16'hFFFF, 16'hFF80));
         found = (i % 2 == 0) ? BIN_BITS'($urandom_range(16'hFFFF, 16'hFF00))
                              : BIN_BITS'($urandom);
         send_bin_pair(key, found, i == SAT_BINS - 1, 1'b0, '0);
      end

      // short random vectors
      sent = 0;
      vec = 0;
      while (sent < SHORT_BINS) begin
         if (vec == 8)
            hold_request = HOLD_LEN;
         steady = (vec >= 20 && vec < 30);
         len = $urandom_range(8, 1);
         zero_key = ($urandom_range(9) == 0);
         for (int i = 0; i < len; i++) begin
            key   = zero_key ? '0 : pick_bin();
            found = ($urandom_range(7) == 0) ? key : pick_bin();
            send_bin_pair(key, found, i == len - 1, 1'b0, '0);
         end
         sent += len;
         vec++;
      end
      steady = 1'b0;

      drain_distances();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("histogram_intersection_distance regression: pass");
      else
         $display("histogram_intersection_distance regression: fail");
      $finish;
   end

endmodule
